// ===== src/free_list_segment_allocator_unit_macros.svh =====
// Assertion macros for the segment allocator.
// Used by the top level only; no other dependencies.
`ifndef FREE_LIST_SEGMENT_ALLOCATOR_UNIT_MACROS_SVH
`define FREE_LIST_SEGMENT_ALLOCATOR_UNIT_MACROS_SVH
`define FLSA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FLSA_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== src/flsa_pkg.sv =====
// Package for the segment allocator: item types, status codes, defaults.
// No dependencies.
package flsa_pkg;
  localparam int unsigned ArenaBytesDef  = 65536;
  localparam int unsigned HeaderBytesDef = 32;
  localparam int unsigned MaxSegmentsDef = 64;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOTALLOC = 3'd4;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] req_size;
    logic [15:0] payload_addr;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_addr;
    logic [2:0]  status;
  } out_item_t;

  // one table entry: header offset (17b), payload size (17b), busy
  typedef struct packed {
    logic [16:0] hdr;
    logic [16:0] size;
    logic        busy;
  } seg_t;

  localparam int unsigned SegW = $bits(seg_t);
endpackage

// ===== src/flsa_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module flsa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/free_list_segment_allocator_unit.sv =====
// Segment allocator: address-ordered segment table in one RAM, walked by a sequencer.
// An alloc walks the table, then spends one read and one write per shifted entry on the
// single RAM port; a free merges with free neighbours and moves later entries down.
// Items are handled one at a time; the next item is taken in the cycle after the result is registered.
// Reset (synchronous, rst_n low) sets count to one; entry 0 is written in the S_INIT state that follows.
// Depends on flsa_pkg, flsa_ram and the macros header.
`include "free_list_segment_allocator_unit_macros.svh"
module free_list_segment_allocator_unit #(
  parameter int unsigned ArenaBytes  = flsa_pkg::ArenaBytesDef,
  parameter int unsigned HeaderBytes = flsa_pkg::HeaderBytesDef,
  parameter int unsigned MaxSegments = flsa_pkg::MaxSegmentsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  flsa_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output flsa_pkg::out_item_t out_data
);
  localparam int unsigned AW = $clog2(MaxSegments);
  localparam int unsigned CW = $clog2(MaxSegments + 1);
  localparam logic [16:0] Hdr  = 17'(HeaderBytes);
  localparam logic [16:0] Lo   = 17'(3 * HeaderBytes);
  localparam logic [16:0] Hi   = 17'(ArenaBytes + HeaderBytes);
  localparam logic [16:0] Hdr0 = 17'(2 * HeaderBytes);
  localparam logic [16:0] Sz0  = 17'(ArenaBytes - 3 * HeaderBytes);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_SRD, S_SCHK, S_DEC, S_SHR, S_SHW, S_WRA, S_WRB,
    S_NRD, S_NCHK, S_PRD, S_PCHK, S_RMR, S_RMW, S_DONE
  } st_t;

  st_t st_r;
  logic [1:0] pol_r;
  logic [CW-1:0] cnt_r;
  flsa_pkg::in_item_t it_r;
  logic [AW-1:0] idx_r, pick_r, tgt_r, rm_r;
  logic found_r;
  logic [16:0] best_r, bhdr_r;
  flsa_pkg::seg_t cur_r, nb_r;
  logic [CW-1:0] sh_r;
  logic ov_r;
  flsa_pkg::out_item_t res_r;
  flsa_pkg::out_item_t out_r;

  logic ram_we;
  logic [AW-1:0] ram_wa, ram_ra;
  flsa_pkg::seg_t ram_wd, rd;
  logic [flsa_pkg::SegW-1:0] rd_raw;
  assign rd = flsa_pkg::seg_t'(rd_raw);

  flsa_ram #(.Width(flsa_pkg::SegW), .Depth(MaxSegments)) u_tbl (
    .clk(clk), .we(ram_we), .waddr(ram_wa), .wdata(ram_wd),
    .raddr(ram_ra), .rdata(rd_raw)
  );

  logic [16:0] req17;
  assign req17 = {1'b0, it_r.req_size};
  logic [16:0] addr17;
  assign addr17 = {1'b0, it_r.payload_addr};
  logic pol_sel;
  assign pol_sel = (pol_r == flsa_pkg::POL_BEST) || (pol_r == flsa_pkg::POL_WORST);

  assign in_stall  = (st_r != S_IDLE);
  assign out_data  = out_r;

  always_comb begin
    ram_we = 1'b0; ram_wa = '0; ram_wd = '0; ram_ra = idx_r;
    case (st_r)
      S_INIT: begin
        ram_we = 1'b1; ram_wd = '{hdr: Hdr0, size: Sz0, busy: 1'b0};
      end
      S_SHR, S_RMR: ram_ra = idx_r;
      S_SHW: begin ram_we = 1'b1; ram_wa = idx_r + AW'(1); ram_wd = rd; end
      // removal write: entry idx moves down by sh_r
      S_RMW: begin ram_we = 1'b1; ram_wa = idx_r - AW'(sh_r); ram_wd = rd; end
      S_WRA: begin ram_we = 1'b1; ram_wa = tgt_r; ram_wd = cur_r; end
      S_WRB: begin ram_we = 1'b1; ram_wa = tgt_r + AW'(1); ram_wd = nb_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_INIT; pol_r <= flsa_pkg::POL_FIRST;
      cnt_r <= CW'(1); out_valid <= 1'b0;
    end else begin
      if (cfg_we) pol_r <= cfg_wdata;
      if (st_r == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st_r)
        S_INIT: st_r <= S_IDLE;
        S_IDLE: if (in_valid && !in_stall) begin
          it_r <= in_data; idx_r <= '0; found_r <= 1'b0; best_r <= '0; pick_r <= '0;
          if (in_data.kind == flsa_pkg::KIND_FREE &&
              (({1'b0, in_data.payload_addr} < Lo) || ({1'b0, in_data.payload_addr} > Hi))) begin
            res_r <= '{result_addr: '0, status: flsa_pkg::ST_RANGE}; st_r <= S_DONE;
          end else st_r <= S_SRD;
        end
        S_SRD: st_r <= S_SCHK;
        S_SCHK: begin
          if (it_r.kind == flsa_pkg::KIND_ALLOC) begin
            if (!rd.busy && rd.size >= req17 && (!found_r ||
                (pol_r == flsa_pkg::POL_BEST && rd.size < best_r) ||
                (pol_r == flsa_pkg::POL_WORST && rd.size > best_r))) begin
              found_r <= 1'b1; pick_r <= idx_r; best_r <= rd.size; bhdr_r <= rd.hdr;
              if (!pol_sel) begin idx_r <= idx_r; st_r <= S_DEC; end
              else if (CW'(idx_r) + CW'(1) >= cnt_r) st_r <= S_DEC;
              else begin idx_r <= idx_r + AW'(1); st_r <= S_SRD; end
            end else if (CW'(idx_r) + CW'(1) >= cnt_r) st_r <= S_DEC;
            else begin idx_r <= idx_r + AW'(1); st_r <= S_SRD; end
          end else begin
            if (rd.busy && rd.hdr == addr17 - Hdr) begin
              tgt_r <= idx_r; cur_r <= '{hdr: rd.hdr, size: rd.size, busy: 1'b0};
              if (CW'(idx_r) + CW'(1) < cnt_r) begin
                idx_r <= idx_r + AW'(1); st_r <= S_NRD;
              end else begin
                idx_r <= idx_r - AW'(1); ov_r <= 1'b0; sh_r <= '0; st_r <= S_PRD;
              end
            end else if (CW'(idx_r) + CW'(1) >= cnt_r) begin
              res_r <= '{result_addr: '0, status: flsa_pkg::ST_NOTALLOC}; st_r <= S_DONE;
            end else begin idx_r <= idx_r + AW'(1); st_r <= S_SRD; end
          end
        end
        S_DEC: begin
          if (!found_r) begin
            res_r <= '{result_addr: '0, status: flsa_pkg::ST_NOFIT}; st_r <= S_DONE;
          end else begin
            tgt_r <= pick_r;
            if (best_r - req17 > Hdr) begin
              if (cnt_r >= CW'(MaxSegments)) begin
                res_r <= '{result_addr: '0, status: flsa_pkg::ST_FULL}; st_r <= S_DONE;
              end else begin
                cur_r <= '{hdr: bhdr_r, size: req17, busy: 1'b1};
                nb_r <= '{hdr: bhdr_r + Hdr + req17, size: best_r - req17 - Hdr, busy: 1'b0};
                res_r <= '{result_addr: 16'(bhdr_r + Hdr), status: flsa_pkg::ST_OK};
                cnt_r <= cnt_r + CW'(1);
                if (cnt_r > CW'(pick_r) + CW'(1)) begin
                  idx_r <= AW'(cnt_r - CW'(1)); st_r <= S_SHR;
                end else st_r <= S_WRB;
              end
            end else begin
              cur_r <= '{hdr: bhdr_r, size: best_r, busy: 1'b1};
              res_r <= '{result_addr: 16'(bhdr_r + Hdr), status: flsa_pkg::ST_OK};
              st_r <= S_WRA;
            end
          end
        end
        S_SHR: st_r <= S_SHW;
        S_SHW: begin
          if (idx_r == pick_r + AW'(1)) st_r <= S_WRB;
          else begin idx_r <= idx_r - AW'(1); st_r <= S_SHR; end
        end
        S_WRB: st_r <= S_WRA;
        S_WRA: begin
          if (it_r.kind == flsa_pkg::KIND_FREE) begin
            res_r <= '{result_addr: '0, status: flsa_pkg::ST_OK};
            if (sh_r != '0 && CW'(rm_r) + sh_r < cnt_r) begin
              idx_r <= AW'(CW'(rm_r) + sh_r); st_r <= S_RMR;
            end else begin cnt_r <= cnt_r - sh_r; st_r <= S_DONE; end
          end else st_r <= S_DONE;
        end
        S_NRD: st_r <= S_NCHK;
        S_NCHK: begin
          if (!rd.busy) begin
            cur_r.size <= cur_r.size + Hdr + rd.size;
            ov_r <= 1'b1; rm_r <= tgt_r + AW'(1);
          end else ov_r <= 1'b0;
          idx_r <= tgt_r - AW'(1);
          st_r <= (tgt_r != '0) ? S_PRD : S_WRA;
          if (tgt_r == '0 && !rd.busy) sh_r <= CW'(1);
          else sh_r <= '0;
        end
        S_PRD: begin
          if (tgt_r == '0) begin ov_r <= ov_r; st_r <= S_WRA; end
          else begin idx_r <= tgt_r - AW'(1); st_r <= S_PCHK; end
        end
        S_PCHK: begin
          if (!rd.busy) begin
            cur_r <= '{hdr: rd.hdr, size: rd.size + Hdr + cur_r.size, busy: 1'b0};
            tgt_r <= tgt_r - AW'(1);
            if (ov_r) sh_r <= CW'(2); else begin sh_r <= CW'(1); rm_r <= tgt_r; end
            if (ov_r) rm_r <= tgt_r;
          end else if (ov_r) sh_r <= CW'(1);
          else sh_r <= '0;
          st_r <= S_WRA;
        end
        S_RMR: st_r <= S_RMW;
        S_RMW: begin
          if (CW'(idx_r) + CW'(1) >= cnt_r) begin
            cnt_r <= cnt_r - sh_r; st_r <= S_DONE;
          end else begin idx_r <= idx_r + AW'(1); st_r <= S_RMR; end
        end
        S_DONE: if (!out_valid || !out_stall) begin
          out_r <= res_r; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `FLSA_ASSERT(a_cnt_range, clk, rst_n, cnt_r >= CW'(1) && cnt_r <= CW'(MaxSegments),
    "segment count out of range")
  `FLSA_ASSERT(a_stall_busy, clk, rst_n, (st_r != S_IDLE) |-> in_stall,
    "item accepted while busy")
  `FLSA_ASSERT(a_ok_addr, clk, rst_n,
    $rose(out_valid) && out_data.status != flsa_pkg::ST_OK |-> out_data.result_addr == '0,
    "nonzero address on error")
endmodule

// ===== bench/tb_free_list_segment_allocator_unit.sv =====
// Testbench for the free-list segment allocator: directed and random allocate/free traffic
// under all fit policies, checked against an in-bench segment table predictor.
// Depends on flsa_pkg and the free_list_segment_allocator_unit RTL.
`timescale 1ns / 1ps

class alloc_scoreboard;
  localparam int Hdr = int'(flsa_pkg::HeaderBytesDef);
  localparam int Arena = int'(flsa_pkg::ArenaBytesDef);
  localparam int MaxSeg = int'(flsa_pkg::MaxSegmentsDef);
  bit [16:0] seg_hdr[MaxSeg];
  bit [16:0] seg_size[MaxSeg];
  bit        seg_busy[MaxSeg];
  int        seg_cnt;
  bit [1:0]  policy;
  flsa_pkg::out_item_t pending[$];
  int        errors;
  int        checked;
  int        n_ok, n_nofit, n_full, n_range, n_notalloc;

  function void clear_table();
    seg_cnt = 1;
    seg_hdr[0] = 2 * Hdr;
    seg_size[0] = Arena - 3 * Hdr;
    seg_busy[0] = 0;
    policy = flsa_pkg::POL_FIRST;
  endfunction

  function void drop_entry(int i);
    for (int j = i; j < seg_cnt - 1; j++) begin
      seg_hdr[j] = seg_hdr[j + 1];
      seg_size[j] = seg_size[j + 1];
      seg_busy[j] = seg_busy[j + 1];
    end
    seg_cnt--;
  endfunction

  function flsa_pkg::out_item_t allocate(bit [15:0] req);
    flsa_pkg::out_item_t r;
    int pick;
    bit found;
    bit [16:0] fit;
    r = '0;
    found = 0;
    pick = 0;
    fit = 0;
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_busy[i] || seg_size[i] < req) continue;
      if (!found || (policy == flsa_pkg::POL_BEST && seg_size[i] < fit) ||
          (policy == flsa_pkg::POL_WORST && seg_size[i] > fit)) begin
        found = 1;
        pick = i;
        fit = seg_size[i];
        if (policy != flsa_pkg::POL_BEST && policy != flsa_pkg::POL_WORST) break;
      end
    end
    if (!found) begin
      r.status = flsa_pkg::ST_NOFIT;
      return r;
    end
    if (fit - req > Hdr) begin
      if (seg_cnt >= MaxSeg) begin
        r.status = flsa_pkg::ST_FULL;
        return r;
      end
      for (int j = seg_cnt; j > pick + 1; j--) begin
        seg_hdr[j] = seg_hdr[j - 1];
        seg_size[j] = seg_size[j - 1];
        seg_busy[j] = seg_busy[j - 1];
      end
      seg_cnt++;
      seg_hdr[pick + 1] = seg_hdr[pick] + Hdr + req;
      seg_size[pick + 1] = fit - req - Hdr;
      seg_busy[pick + 1] = 0;
      seg_size[pick] = req;
    end
    seg_busy[pick] = 1;
    r.result_addr = 16'(seg_hdr[pick] + Hdr);
    r.status = flsa_pkg::ST_OK;
    return r;
  endfunction

  function flsa_pkg::out_item_t release_addr(bit [15:0] addr);
    flsa_pkg::out_item_t r;
    int i;
    int h;
    r = '0;
    if (addr < 3 * Hdr) begin
      r.status = flsa_pkg::ST_RANGE;
      return r;
    end
    h = int'(addr) - Hdr;
    if (h > Arena) begin
      r.status = flsa_pkg::ST_RANGE;
      return r;
    end
    for (i = 0; i < seg_cnt; i++)
      if (seg_busy[i] && seg_hdr[i] == h) break;
    if (i >= seg_cnt) begin
      r.status = flsa_pkg::ST_NOTALLOC;
      return r;
    end
    seg_busy[i] = 0;
    if (i + 1 < seg_cnt && !seg_busy[i + 1]) begin
      seg_size[i] += Hdr + seg_size[i + 1];
      drop_entry(i + 1);
    end
    if (i > 0 && !seg_busy[i - 1]) begin
      seg_size[i - 1] += Hdr + seg_size[i];
      drop_entry(i);
    end
    r.status = flsa_pkg::ST_OK;
    return r;
  endfunction

  function void note_request(flsa_pkg::in_item_t it);
    flsa_pkg::out_item_t r;
    r = (it.kind == flsa_pkg::KIND_ALLOC) ? allocate(it.req_size)
                                           : release_addr(it.payload_addr);
    case (r.status)
      flsa_pkg::ST_OK: n_ok++;
      flsa_pkg::ST_NOFIT: n_nofit++;
      flsa_pkg::ST_FULL: n_full++;
      flsa_pkg::ST_RANGE: n_range++;
      default: n_notalloc++;
    endcase
    pending.push_back(r);
  endfunction

  task report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task check_result(flsa_pkg::out_item_t got);
    flsa_pkg::out_item_t want;
    if (pending.size() == 0) begin
      report("unexpected item", got, 0);
      return;
    end
    want = pending.pop_front();
    checked++;
    if (got.result_addr !== want.result_addr)
      report("result_addr", got.result_addr, want.result_addr);
    if (got.status !== want.status) report("status", got.status, want.status);
  endtask

  function bit [15:0] busy_payload();
    int idx[$];
    for (int i = 0; i < seg_cnt; i++) if (seg_busy[i]) idx.push_back(i);
    if (idx.size() == 0) return 16'd64;
    return 16'(seg_hdr[idx[$urandom_range(idx.size() - 1)]] + Hdr);
  endfunction
endclass

module tb_free_list_segment_allocator_unit;
  logic      clk = 0;
  logic      rst_n = 0;
  logic      cfg_we = 0;
  logic [1:0] cfg_wdata = '0;
  logic      in_valid = 0;
  logic      in_stall;
  flsa_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  flsa_pkg::out_item_t out_data;
  alloc_scoreboard sb;
  bit        sending_done = 0;

  free_list_segment_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  initial begin
    #50ms;
    $display("[free_list_segment_allocator_unit] ERROR");
    $finish;
  end

  // valid stays high after an accept; the next call or the caller drops it
  task send_item(flsa_pkg::in_item_t it);
    int gap;
    gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(it);
  endtask

  task send_alloc(bit [15:0] sz);
    flsa_pkg::in_item_t it;
    it = '0;
    it.kind = flsa_pkg::KIND_ALLOC;
    it.req_size = sz;
    it.payload_addr = 16'($urandom);
    send_item(it);
  endtask

  task send_free(bit [15:0] a);
    flsa_pkg::in_item_t it;
    it = '0;
    it.kind = flsa_pkg::KIND_FREE;
    it.payload_addr = a;
    it.req_size = 16'($urandom);
    send_item(it);
  endtask

  task drain_then_config(bit [1:0] pol);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= pol;
    @(posedge clk);
    cfg_we <= 0;
    sb.policy = pol;
  endtask

  task random_phase(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        if ($urandom_range(9) == 0) send_alloc(16'($urandom));
        else if ($urandom_range(3) == 0) send_alloc(16'($urandom_range(40)));
        else send_alloc(16'($urandom_range(2000)));
      end else if (r < 90) send_free(sb.busy_payload());
      else send_free(16'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  initial begin
    int wait_cnt;
    while (!sending_done || sb.pending.size() != 0) begin
      wait_cnt = ($urandom_range(3) == 0) ? 0 : $urandom_range(17);
      if (wait_cnt != 0) begin
        out_stall <= 1;
        repeat (wait_cnt) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    sb = new();
    sb.clear_table();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: range edges, zero size, huge size, double free, exact fit
    send_free(16'd0);
    send_free(16'd95);
    send_free(16'hFFFF);
    send_free(16'd96);
    send_alloc(16'hFFFF);
    send_alloc(16'd0);
    send_alloc(16'd100);
    send_alloc(16'd64);
    send_free(16'd96);
    send_free(16'd96);
    send_alloc(16'd0);
    send_alloc(16'd65440);
    send_alloc(16'd10);
    for (int k = 0; k < 70; k++) send_alloc(16'd8);
    for (int p = 0; p < 4; p++) begin
      drain_then_config(2'(p));
      random_phase(p == 3 ? 300 : 400);
      for (int k = 0; k < 20; k++) send_free(sb.busy_payload());
    end
    drain_then_config(flsa_pkg::POL_WORST);
    random_phase(100);
    drain_then_config(flsa_pkg::POL_FIRST);
    random_phase(50);
    sending_done = 1;
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d results: ok %0d, no fit %0d, full %0d, range %0d, not allocated %0d",
             sb.checked, sb.n_ok, sb.n_nofit, sb.n_full, sb.n_range, sb.n_notalloc);
    $display("all four fit policy codes exercised, %0d mismatches", sb.errors);
    if (sb.errors == 0) $display("[free_list_segment_allocator_unit] OK");
    else $display("[free_list_segment_allocator_unit] ERROR");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/flsa_pkg.sv
src/flsa_ram.sv
src/free_list_segment_allocator_unit.sv
bench/tb_free_list_segment_allocator_unit.sv
